FILE: sv/gaussian_blur_5x5_assert.svh
// assertion macros for the gaussian blur block
`ifndef GAUSSIAN_BLUR_5X5_ASSERT_SVH
`define GAUSSIAN_BLUR_5X5_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GB5_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gaussian_blur_5x5: same-cycle check failed");

// next-cycle implication, checked out of reset
`define GB5_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gaussian_blur_5x5: next-cycle check failed");

`endif

FILE: sv/gb5_pkg.sv
// shared constants, types and register codes of the gaussian blur block
package gb5_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int STORE_ROWS = 4;
  localparam int LANE_W     = $clog2(STORE_ROWS);
  localparam int KSIZE      = 5;
  localparam int HALF_K     = 2;
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int DIM_W      = 12;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MIN_DIM    = 5;
  localparam int FRAC_W     = 16;
  localparam int ACC_W      = 29;

  localparam logic [DIM_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 12'd480;
  localparam logic [COEF_W-1:0] C0_RST     = 16'd10623;
  localparam logic [COEF_W-1:0] C1_RST     = 16'd6443;
  localparam logic [COEF_W-1:0] C2_RST     = 16'd3906;
  localparam logic [COEF_W-1:0] C4_RST     = 16'd1436;
  localparam logic [COEF_W-1:0] C5_RST     = 16'd871;
  localparam logic [COEF_W-1:0] C8_RST     = 16'd196;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_C0     = 3'd2,
    CFG_C1     = 3'd3,
    CFG_C2     = 3'd4,
    CFG_C4     = 3'd5,
    CFG_C5     = 3'd6,
    CFG_C8     = 3'd7
  } cfg_idx_e;

  // position info that follows one pixel down the pipeline
  typedef struct packed {
    logic             emit;
    logic             done;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

  // weights by squared distance from the centre tap
  typedef struct packed {
    logic [COEF_W-1:0] c0;
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c8;
  } coef_t;

  // window pixels summed per weight class
  typedef struct packed {
    logic [PIX_W-1:0]   g0;
    logic [PIX_W+1:0]   g1;
    logic [PIX_W+1:0]   g2;
    logic [PIX_W+1:0]   g4;
    logic [PIX_W+2:0]   g5;
    logic [PIX_W+1:0]   g8;
  } gsum_t;

endpackage

FILE: sv/gb5_pos.sv
// raster position counters, interior test and line store addressing
module gb5_pos (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  logic                        sof_i,
  input  logic [gb5_pkg::DIM_W-1:0]   width_i,
  input  logic [gb5_pkg::DIM_W-1:0]   height_i,
  output gb5_pkg::pos_t               pos_o,
  output logic [gb5_pkg::ADDR_W-1:0]  addr_o,
  output logic [gb5_pkg::LANE_W-1:0]  lane_o
);

  logic [gb5_pkg::COL_W-1:0] col_q, col_d;
  logic [gb5_pkg::ROW_W-1:0] row_q, row_d;
  logic [gb5_pkg::COL_W-1:0] c;
  logic [gb5_pkg::ROW_W-1:0] r;
  logic [gb5_pkg::DIM_W-1:0] wcl, hcl;
  logic [gb5_pkg::DIM_W-1:0] c_ext;
  logic [gb5_pkg::DIM_W:0]   r_inc;

  always_comb begin
    if (width_i < gb5_pkg::DIM_W'(gb5_pkg::MIN_DIM)) begin
      wcl = gb5_pkg::DIM_W'(gb5_pkg::MIN_DIM);
    end else if (width_i > gb5_pkg::DIM_W'(gb5_pkg::MAX_WIDTH)) begin
      wcl = gb5_pkg::DIM_W'(gb5_pkg::MAX_WIDTH);
    end else begin
      wcl = width_i;
    end
    if (height_i < gb5_pkg::DIM_W'(gb5_pkg::MIN_DIM)) begin
      hcl = gb5_pkg::DIM_W'(gb5_pkg::MIN_DIM);
    end else begin
      hcl = height_i;
    end

    // start of frame makes this pixel (0,0)
    c     = sof_i ? '0 : col_q;
    r     = sof_i ? '0 : row_q;
    c_ext = gb5_pkg::DIM_W'(c);
    r_inc = {1'b0, r} + 1'b1;

    pos_o.emit = (r >= gb5_pkg::ROW_W'(2 * gb5_pkg::HALF_K))
              && (c >= gb5_pkg::COL_W'(2 * gb5_pkg::HALF_K))
              && (r < hcl) && (c_ext < wcl);
    pos_o.done = (r == hcl - 1'b1) && (c_ext == wcl - 1'b1);
    pos_o.row  = r - gb5_pkg::ROW_W'(gb5_pkg::HALF_K);
    pos_o.col  = c - gb5_pkg::COL_W'(gb5_pkg::HALF_K);

    addr_o = c;
    lane_o = r[gb5_pkg::LANE_W-1:0];

    if (c_ext + 1'b1 >= wcl) begin
      col_d = '0;
      row_d = (r_inc >= {1'b0, hcl}) ? '0 : r_inc[gb5_pkg::ROW_W-1:0];
    end else begin
      col_d = c + 1'b1;
      row_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: sv/gb5_line_mem.sv
// line store: one word per column, one byte lane per stored row
module gb5_line_mem (
  input  logic                                          clk_i,
  input  logic                                          acc_i,
  input  logic [gb5_pkg::ADDR_W-1:0]                    addr_i,
  input  logic [gb5_pkg::LANE_W-1:0]                    lane_i,
  input  logic [gb5_pkg::PIX_W-1:0]                     pix_i,
  output logic [gb5_pkg::STORE_ROWS-1:0][gb5_pkg::PIX_W-1:0] rd_o
);

  logic [gb5_pkg::STORE_ROWS-1:0][gb5_pkg::PIX_W-1:0] mem [gb5_pkg::MAX_WIDTH];
  logic [gb5_pkg::STORE_ROWS-1:0][gb5_pkg::PIX_W-1:0] rd_q;

  // read-first: the word read holds the old byte of the lane being replaced,
  // and the next access to this column sees the new byte
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      mem[addr_i][lane_i] <= pix_i;
      rd_q                <= mem[addr_i];
    end
  end

  assign rd_o = rd_q;

endmodule

FILE: sv/gb5_window.sv
// 5x5 pixel window and per-weight-class pixel sums
module gb5_window (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               shift_i,
  input  logic                                               adv_i,
  input  logic [gb5_pkg::STORE_ROWS-1:0][gb5_pkg::PIX_W-1:0] rd_i,
  input  logic [gb5_pkg::LANE_W-1:0]                         lane_i,
  input  logic [gb5_pkg::PIX_W-1:0]                          pix_i,
  output gb5_pkg::gsum_t                                     gsum_o
);

  logic [gb5_pkg::PIX_W-1:0] win_q [gb5_pkg::KSIZE][gb5_pkg::KSIZE];
  logic [gb5_pkg::PIX_W-1:0] column [gb5_pkg::KSIZE];
  gb5_pkg::gsum_t            gsum_q, gsum_d;

  // oldest stored row sits in the lane of the incoming row
  always_comb begin
    for (int k = 0; k < gb5_pkg::STORE_ROWS; k++) begin
      column[k] = rd_i[gb5_pkg::LANE_W'(lane_i + gb5_pkg::LANE_W'(k))];
    end
    column[gb5_pkg::KSIZE-1] = pix_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < gb5_pkg::KSIZE; k++) begin
        for (int m = 0; m < gb5_pkg::KSIZE; m++) begin
          win_q[k][m] <= '0;
        end
      end
    end else if (shift_i) begin
      for (int k = 0; k < gb5_pkg::KSIZE; k++) begin
        for (int m = 0; m < gb5_pkg::KSIZE - 1; m++) begin
          win_q[k][m] <= win_q[k][m+1];
        end
        win_q[k][gb5_pkg::KSIZE-1] <= column[k];
      end
    end
  end

  always_comb begin
    gsum_d.g0 = win_q[2][2];
    gsum_d.g1 = 10'(win_q[1][2]) + 10'(win_q[3][2]) + 10'(win_q[2][1]) + 10'(win_q[2][3]);
    gsum_d.g2 = 10'(win_q[1][1]) + 10'(win_q[1][3]) + 10'(win_q[3][1]) + 10'(win_q[3][3]);
    gsum_d.g4 = 10'(win_q[0][2]) + 10'(win_q[4][2]) + 10'(win_q[2][0]) + 10'(win_q[2][4]);
    gsum_d.g5 = 11'(win_q[0][1]) + 11'(win_q[0][3]) + 11'(win_q[4][1]) + 11'(win_q[4][3])
              + 11'(win_q[1][0]) + 11'(win_q[3][0]) + 11'(win_q[1][4]) + 11'(win_q[3][4]);
    gsum_d.g8 = 10'(win_q[0][0]) + 10'(win_q[0][4]) + 10'(win_q[4][0]) + 10'(win_q[4][4]);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      gsum_q <= gsum_d;
    end
  end

  assign gsum_o = gsum_q;

endmodule

FILE: sv/gb5_mac.sv
// weight multiply stage and accumulation of the six class products
module gb5_mac (
  input  logic                       clk_i,
  input  logic                       adv_i,
  input  gb5_pkg::gsum_t             gsum_i,
  input  gb5_pkg::coef_t             coef_i,
  output logic [gb5_pkg::ACC_W-1:0]  acc_o
);

  logic [23:0]               p0_q;
  logic [25:0]               p1_q, p2_q, p4_q, p8_q;
  logic [26:0]               p5_q;
  logic [gb5_pkg::ACC_W-1:0] acc_q, acc_d;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p0_q <= gsum_i.g0 * coef_i.c0;
      p1_q <= gsum_i.g1 * coef_i.c1;
      p2_q <= gsum_i.g2 * coef_i.c2;
      p4_q <= gsum_i.g4 * coef_i.c4;
      p5_q <= gsum_i.g5 * coef_i.c5;
      p8_q <= gsum_i.g8 * coef_i.c8;
    end
  end

  // full-scale sum stays below 2^29
  assign acc_d = gb5_pkg::ACC_W'(p0_q) + gb5_pkg::ACC_W'(p1_q) + gb5_pkg::ACC_W'(p2_q)
               + gb5_pkg::ACC_W'(p4_q) + gb5_pkg::ACC_W'(p5_q) + gb5_pkg::ACC_W'(p8_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: sv/gaussian_blur_5x5.sv
// Streaming 5x5 Gaussian blur on 8-bit grey pixels in raster order. One pixel is
// taken per clock unless the output stalls; the limit is the single line store
// port, which reads the four stored rows of a column and writes the new pixel in
// the same cycle. An interior pixel's result is registered at the output; edge
// pixels give no result. A stall on the output holds the whole pipeline. The line
// store comes out of reset unwritten and needs no clearing pass: each entry is
// written before an interior window reads it. The user makes configuration writes
// only while no pixel is in flight; the block does not enforce it.
module gaussian_blur_5x5 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gb5_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gb5_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gb5_pkg::PIX_W-1:0]         in_pixel_i,
  input  logic                              start_of_frame_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gb5_pkg::PIX_W-1:0]         out_pixel_o,
  output logic [gb5_pkg::ROW_W-1:0]         centre_row_o,
  output logic [gb5_pkg::COL_W-1:0]         centre_col_o,
  output logic                              frame_done_o
);

  logic [gb5_pkg::DIM_W-1:0] width_q, height_q;
  gb5_pkg::coef_t            coef_q;

  logic                      adv, in_acc;
  gb5_pkg::pos_t             pos;
  logic [gb5_pkg::ADDR_W-1:0] addr;
  logic [gb5_pkg::LANE_W-1:0] lane;
  logic [gb5_pkg::STORE_ROWS-1:0][gb5_pkg::PIX_W-1:0] rd;
  gb5_pkg::gsum_t            gsum;
  logic [gb5_pkg::ACC_W-1:0] acc;

  logic                      v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  gb5_pkg::pos_t             m1_q, m2_q, m3_q, m4_q, m5_q;
  logic [gb5_pkg::PIX_W-1:0] pix1_q;
  logic [gb5_pkg::LANE_W-1:0] lane1_q;
  logic [gb5_pkg::PIX_W-1:0] out_pixel_q, out_pixel_d;
  gb5_pkg::pos_t             out_meta_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= gb5_pkg::WIDTH_RST;
      height_q  <= gb5_pkg::HEIGHT_RST;
      coef_q.c0 <= gb5_pkg::C0_RST;
      coef_q.c1 <= gb5_pkg::C1_RST;
      coef_q.c2 <= gb5_pkg::C2_RST;
      coef_q.c4 <= gb5_pkg::C4_RST;
      coef_q.c5 <= gb5_pkg::C5_RST;
      coef_q.c8 <= gb5_pkg::C8_RST;
    end else if (cfg_we_i) begin
      case (gb5_pkg::cfg_idx_e'(cfg_idx_i))
        gb5_pkg::CFG_WIDTH:  width_q   <= cfg_wdata_i[gb5_pkg::DIM_W-1:0];
        gb5_pkg::CFG_HEIGHT: height_q  <= cfg_wdata_i[gb5_pkg::DIM_W-1:0];
        gb5_pkg::CFG_C0:     coef_q.c0 <= cfg_wdata_i;
        gb5_pkg::CFG_C1:     coef_q.c1 <= cfg_wdata_i;
        gb5_pkg::CFG_C2:     coef_q.c2 <= cfg_wdata_i;
        gb5_pkg::CFG_C4:     coef_q.c4 <= cfg_wdata_i;
        gb5_pkg::CFG_C5:     coef_q.c5 <= cfg_wdata_i;
        gb5_pkg::CFG_C8:     coef_q.c8 <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // the whole pipeline moves unless a finished result is still waiting
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign in_acc     = in_valid_i && adv;

  gb5_pos u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (in_acc),
    .sof_i    (start_of_frame_i),
    .width_i  (width_q),
    .height_i (height_q),
    .pos_o    (pos),
    .addr_o   (addr),
    .lane_o   (lane)
  );

  gb5_line_mem u_line_mem (
    .clk_i  (clk_i),
    .acc_i  (in_acc),
    .addr_i (addr),
    .lane_i (lane),
    .pix_i  (in_pixel_i),
    .rd_o   (rd)
  );

  gb5_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (adv && v1_q),
    .adv_i   (adv),
    .rd_i    (rd),
    .lane_i  (lane1_q),
    .pix_i   (pix1_q),
    .gsum_o  (gsum)
  );

  gb5_mac u_mac (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .gsum_i (gsum),
    .coef_i (coef_q),
    .acc_o  (acc)
  );

  // valid bits; after the window only pixels with a result travel on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_acc;
      v2_q        <= v1_q && m1_q.emit;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  // truncate the Q13.16 sum and saturate at full scale
  assign out_pixel_d = (acc[gb5_pkg::ACC_W-1:gb5_pkg::FRAC_W+gb5_pkg::PIX_W] != '0)
                     ? '1 : acc[gb5_pkg::FRAC_W+gb5_pkg::PIX_W-1:gb5_pkg::FRAC_W];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix1_q  <= in_pixel_i;
      lane1_q <= lane;
    end
    if (adv) begin
      m1_q        <= pos;
      m2_q        <= m1_q;
      m3_q        <= m2_q;
      m4_q        <= m3_q;
      m5_q        <= m4_q;
      out_meta_q  <= m5_q;
      out_pixel_q <= out_pixel_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_pixel_o  = out_pixel_q;
  assign centre_row_o = out_meta_q.row;
  assign centre_col_o = out_meta_q.col;
  assign frame_done_o = out_meta_q.done;

`include "gaussian_blur_5x5_assert.svh"

  // a result always sits at least two away from the top and left edges
  `GB5_ASSERT_NOW(a_centre_interior, out_valid_o,
    (centre_row_o >= gb5_pkg::ROW_W'(gb5_pkg::HALF_K)) &&
    (centre_col_o >= gb5_pkg::COL_W'(gb5_pkg::HALF_K)))
  // a waiting result freezes the sum and the stage feeding the output
  `GB5_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i,
    $stable(acc) && $stable(v5_q) && $stable(m5_q))
  // every transfer reaches the window stage on the next edge
  `GB5_ASSERT_NEXT(a_transfer_staged, in_valid_i && in_ready_o, v1_q)

endmodule

FILE: test/tb_gaussian_blur_5x5.sv
// testbench for gaussian_blur_5x5: streamed frames checked against a built-in blur predictor
module tb_gaussian_blur_5x5;
  timeunit 1ns;
  timeprecision 1ps;

  import gb5_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } blur_result_t;

  typedef enum {COEF_MAX, COEF_RANDOM} coef_mode_e;

  class blur_scoreboard;
    bit [DIM_W-1:0]  width_reg;
    bit [DIM_W-1:0]  height_reg;
    bit [COEF_W-1:0] weight[6];
    bit [PIX_W-1:0]  rows_kept[STORE_ROWS][MAX_WIDTH];
    bit [PIX_W-1:0]  win[KSIZE][KSIZE];
    int unsigned     col_pos;
    int unsigned     row_pos;
    blur_result_t    pending[$];
    int unsigned     mismatches;

    function new();
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      weight = '{C0_RST, C1_RST, C2_RST, C4_RST, C5_RST, C8_RST};
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WIDTH: width_reg = data[DIM_W-1:0];
        CFG_HEIGHT: height_reg = data[DIM_W-1:0];
        default: weight[int'(idx) - int'(CFG_C0)] = data;
      endcase
    endfunction

    // shift one pixel into the window and queue the blurred result if interior
    function void note_pixel(logic [PIX_W-1:0] pix, logic sof);
      int unsigned w, h, r, c;
      int d2, sel;
      bit [PIX_W-1:0] column[KSIZE];
      longint unsigned acc;
      blur_result_t res;
      w = width_reg;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = height_reg;
      if (h < MIN_DIM) h = MIN_DIM;
      if (sof) begin
        col_pos = 0;
        row_pos = 0;
      end
      r = row_pos;
      c = col_pos % MAX_WIDTH;
      for (int k = 0; k < STORE_ROWS; k++) column[k] = rows_kept[(r + k) % STORE_ROWS][c];
      column[KSIZE-1] = pix;
      rows_kept[r % STORE_ROWS][c] = pix;
      for (int k = 0; k < KSIZE; k++) begin
        for (int m = 0; m < KSIZE - 1; m++) win[k][m] = win[k][m+1];
        win[k][KSIZE-1] = column[k];
      end
      if (r >= 2 * HALF_K && c >= 2 * HALF_K && r < h && c < w) begin
        acc = 0;
        for (int k = 0; k < KSIZE; k++) begin
          for (int m = 0; m < KSIZE; m++) begin
            d2 = (k - HALF_K) * (k - HALF_K) + (m - HALF_K) * (m - HALF_K);
            case (d2)
              0: sel = 0;
              1: sel = 1;
              2: sel = 2;
              4: sel = 3;
              5: sel = 4;
              default: sel = 5;
            endcase
            acc += weight[sel] * win[k][m];
          end
        end
        acc = acc >> FRAC_W;
        res.pix = (acc > 255) ? 8'hFF : acc[PIX_W-1:0];
        res.row = ROW_W'(r - HALF_K);
        res.col = COL_W'(c - HALF_K);
        res.done = (r == h - 1 && c == w - 1);
        pending.push_back(res);
      end
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_result(blur_result_t got);
      blur_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pix %0d row %0d col %0d done %0b",
                   got.pix, got.row, got.col, got.done);
        return;
      end
      want = pending.pop_front();
      if (got.pix !== want.pix || got.row !== want.row || got.col !== want.col ||
          got.done !== want.done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected pix %0d row %0d col %0d done %0b, got pix %0d row %0d col %0d done %0b",
                   want.pix, want.row, want.col, want.done,
                   got.pix, got.row, got.col, got.done);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [PIX_W-1:0]      in_pixel_i = '0;
  logic                  start_of_frame_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PIX_W-1:0]      out_pixel_o;
  logic [ROW_W-1:0]      centre_row_o;
  logic [COL_W-1:0]      centre_col_o;
  logic                  frame_done_o;

  blur_scoreboard sb = new();
  int unsigned    idle_pct = 13;
  int unsigned    pixels_taken = 0;
  bit             rx_hold = 1'b0;
  bit             rx_force = 1'b0;

  gaussian_blur_5x5 uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_pixel_i       (in_pixel_i),
    .start_of_frame_i (start_of_frame_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_pixel_o      (out_pixel_o),
    .centre_row_o     (centre_row_o),
    .centre_col_o     (centre_col_o),
    .frame_done_o     (frame_done_o)
  );

  always begin
    #2;
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
  end

  task automatic set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] wdata, logic [CFG_DATA_W-1:0] hdata,
                           coef_mode_e mode);
    logic [COEF_W-1:0] cf[6];
    int unsigned pick;
    foreach (cf[i]) begin
      pick = $urandom_range(9);
      if (mode == COEF_MAX || pick == 1) cf[i] = 16'hFFFF;
      else if (pick == 0) cf[i] = '0;
      else if (pick == 2) cf[i] = COEF_W'($urandom);
      else cf[i] = COEF_W'($urandom_range(5000));
    end
    set_reg(CFG_WIDTH, wdata);
    set_reg(CFG_HEIGHT, hdata);
    set_reg(CFG_C0, cf[0]);
    set_reg(CFG_C1, cf[1]);
    set_reg(CFG_C2, cf[2]);
    set_reg(CFG_C4, cf[3]);
    set_reg(CFG_C5, cf[4]);
    set_reg(CFG_C8, cf[5]);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] pix, logic sof);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pixel_i <= pix;
    start_of_frame_i <= sof;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(pix, sof);
    pixels_taken++;
  endtask

  // raster stream; stray frame markers only where asked
  task automatic stream_pixels(int unsigned count, bit first_sof, bit stray_sof);
    logic [PIX_W-1:0] pix;
    logic sof;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(15);
      if (pick == 0) pix = '0;
      else if (pick == 1) pix = '1;
      else pix = PIX_W'($urandom_range(255));
      if (i == 0) sof = first_sof;
      else sof = stray_sof && ($urandom_range(999) < 5);
      send_pixel(pix, sof);
    end
  endtask

  // wait for every result, then let pixels without a result leave the pipeline
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    rx_force = 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rx_force = 1'b0;
    @(posedge clk_i);
  endtask

  // result side
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        sb.check_result('{out_pixel_o, centre_row_o, centre_col_o, frame_done_o});
      if (rx_hold) out_ready_i <= 1'b0;
      else if (rx_force) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  // long receiver hold-off so the pipeline fills and backs up the input
  initial begin
    wait (pixels_taken >= 300);
    @(negedge clk_i);
    rx_hold = 1'b1;
    repeat (400) @(negedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned w, h;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest frame after clamping, full-scale weights: one saturated result
    configure(16'h0000, 16'h0000, COEF_MAX);
    for (int i = 0; i < 25; i++) send_pixel((i % 2) ? 8'hFF : 8'h00, i == 0);
    drain();

    // small frames, one or two per phase, wrapping without a marker
    for (int p = 0; p < 4; p++) begin
      w = $urandom_range(MIN_DIM, 14);
      h = $urandom_range(MIN_DIM, 9);
      idle_pct = (p == 3) ? 0 : 13;
      configure({4'($urandom_range(15)), 12'(w)}, {4'($urandom_range(15)), 12'(h)},
                COEF_RANDOM);
      stream_pixels(w * h * $urandom_range(1, 2) + $urandom_range(w), 1'b1, 1'b1);
      drain();
    end
    idle_pct = 13;

    // tallest height setting
    configure(16'd5, 16'hFFFF, COEF_RANDOM);
    stream_pixels(120, 1'b1, 1'b1);
    drain();

    // shrink width and height mid-frame, counters past the new size
    configure(16'd12, 16'd9, COEF_RANDOM);
    stream_pixels(12 * 6 + 7, 1'b1, 1'b0);
    drain();
    configure(16'd5, 16'd5, COEF_RANDOM);
    stream_pixels(60, 1'b0, 1'b0);
    drain();

    // shrink width only, mid-row
    configure(16'd12, 16'd9, COEF_RANDOM);
    stream_pixels(12 * 3 + 9, 1'b1, 1'b0);
    drain();
    configure(16'd6, 16'd9, COEF_RANDOM);
    stream_pixels(70, 1'b0, 1'b0);
    drain();

    // width above the maximum clamps to the full line: no result in the first rows
    configure(16'hFFFF, 16'd5, COEF_RANDOM);
    stream_pixels(60, 1'b1, 1'b0);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: gaussian_blur_5x5.f
+incdir+sv
sv/gb5_pkg.sv
sv/gb5_pos.sv
sv/gb5_line_mem.sv
sv/gb5_window.sv
sv/gb5_mac.sv
sv/gaussian_blur_5x5.sv
test/tb_gaussian_blur_5x5.sv
